/* sv/ebsc_pkg.sv */
// ----------------------------------------------------------------------------
// ebsc_pkg
// Types and constants shared by the event block structure checker.
// ----------------------------------------------------------------------------
package ebsc_pkg;

   localparam int WORD_W = 16;
   localparam int POS_W  = 22;
   localparam int NHP_W  = 23;
   localparam int OFF_W  = 4;
   localparam int CNT_W  = 2;
   localparam int OUT_ERR_W = 8;

   localparam logic [WORD_W-1:0] ID_UPPER_MASK = 16'hFFC0;
   localparam logic [WORD_W-1:0] ID_EXT_MASK   = 16'h003F;

   localparam logic [3:0] NODE_GENERIC   = 4'h1;
   localparam logic [3:0] NODE_LINK      = 4'h2;
   localparam logic [3:0] NODE_THIRD     = 4'h9;
   localparam logic [3:0] NODE_COUNTER   = 4'hA;
   localparam logic [3:0] NODE_TRACKER   = 4'hB;

   localparam logic [2:0] NUM_LINK       = 3'd1;
   localparam logic [5:0] DATA_COUNTER   = 6'd1;
   localparam logic [5:0] DATA_SLOT_LO   = 6'd2;
   localparam logic [5:0] DATA_SLOT_HI   = 6'd6;
   localparam logic [3:0] TRACKER_SIDE_STRIDE = 4'd6;

   localparam logic [OFF_W-1:0] OFF_ID      = 4'd1;
   localparam logic [OFF_W-1:0] OFF_GEN_LO  = 4'd2;
   localparam logic [OFF_W-1:0] OFF_GEN_HI  = 4'd9;
   localparam logic [OFF_W-1:0] OFF_MAX     = 4'd15;

   localparam logic [NHP_W-1:0] FIRST_HEADER_POS = 23'd2;
   localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

   // Side lookup per node number: bit 1 marks a valid side, bit 0 is the side.
   localparam logic [1:0] SIDE_OF_NODE [8] = '{2'b00, 2'b00, 2'b10, 2'b00,
                                               2'b00, 2'b11, 2'b00, 2'b00};

   typedef struct packed {
      logic        btype_bad;
      logic        node_bad;
      logic [2:0]  main_hit;
      logic [7:0]  counter_hit;
      logic [11:0] tracker_hit;
   } class_type;

   typedef struct packed {
      logic        header_id_bad;
      logic        structure_bad;
      logic [7:0]  type_error_count;
      logic [7:0]  node_error_count;
      logic [2:0]  main_single_mask;
      logic [7:0]  counter_single_mask;
      logic [11:0] tracker_single_mask;
      logic [31:0] run_id;
      logic [15:0] run_mode;
      logic [15:0] run_tag;
      logic [31:0] evt_serial;
      logic [31:0] evt_seconds;
   } summary_type;

endpackage

/* sv/ebsc_req_if.sv */
// ----------------------------------------------------------------------------
// ebsc_req_if
// Input word channel of the event block structure checker.
// ----------------------------------------------------------------------------
interface ebsc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

/* sv/ebsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// ebsc_rsp_if
// Event summary channel of the event block structure checker.
// ----------------------------------------------------------------------------
interface ebsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_id_bad;
   logic        structure_bad;
   logic [7:0]  type_error_count;
   logic [7:0]  node_error_count;
   logic [2:0]  main_single_mask;
   logic [7:0]  counter_single_mask;
   logic [11:0] tracker_single_mask;
   logic [31:0] run_id;
   logic [15:0] run_mode;
   logic [15:0] run_tag;
   logic [31:0] evt_serial;
   logic [31:0] evt_seconds;

   modport source (output valid, output header_id_bad, output structure_bad,
                   output type_error_count, output node_error_count,
                   output main_single_mask, output counter_single_mask,
                   output tracker_single_mask, output run_id, output run_mode,
                   output run_tag, output evt_serial, output evt_seconds,
                   input ready);
   modport sink   (input valid, input header_id_bad, input structure_bad,
                   input type_error_count, input node_error_count,
                   input main_single_mask, input counter_single_mask,
                   input tracker_single_mask, input run_id, input run_mode,
                   input run_tag, input evt_serial, input evt_seconds,
                   output ready);
endinterface

/* sv/ebsc_classify.sv */
// ----------------------------------------------------------------------------
// ebsc_classify
// Splits a sub-block ID into its fields and checks them against the node rules.
// ----------------------------------------------------------------------------
module ebsc_classify
   import ebsc_pkg::*;
(
   input  logic [WORD_W-1:0] id,
   output class_type         cls
);

   logic [2:0] btype;
   logic [3:0] ntype;
   logic [2:0] nnum;
   logic [5:0] dtype;
   logic [1:0] side;
   logic       slot_ok;
   logic [3:0] slot;
   logic [3:0] trk_idx;

   assign btype = id[15:13];
   assign ntype = id[12:9];
   assign nnum  = id[8:6];
   assign dtype = id[5:0];
   assign side  = SIDE_OF_NODE[nnum];

   always_comb begin
      slot_ok = 1'b1;
      slot    = '0;
      if (dtype == '0) begin
         slot = '0;
      end else if (dtype >= DATA_SLOT_LO && dtype <= DATA_SLOT_HI) begin
         slot = 4'(dtype - 6'd1);
      end else begin
         slot_ok = 1'b0;
      end
      trk_idx = slot + (side[0] ? TRACKER_SIDE_STRIDE : 4'd0);
   end

   always_comb begin
      cls = '0;
      cls.btype_bad = (btype != '0);
      unique case (ntype)
         NODE_GENERIC: begin
            if (nnum == '0 && dtype == '0) cls.main_hit[0] = 1'b1;
            else cls.node_bad = 1'b1;
         end
         NODE_LINK: begin
            if (nnum == NUM_LINK && dtype == '0) cls.main_hit[1] = 1'b1;
            else cls.node_bad = 1'b1;
         end
         NODE_THIRD: begin
            if (nnum == '0 && dtype == '0) cls.main_hit[2] = 1'b1;
            else cls.node_bad = 1'b1;
         end
         NODE_COUNTER: begin
            if (dtype == DATA_COUNTER) cls.counter_hit[nnum] = 1'b1;
            else cls.node_bad = 1'b1;
         end
         NODE_TRACKER: begin
            if (slot_ok && side[1]) cls.tracker_hit[trk_idx] = 1'b1;
            else cls.node_bad = 1'b1;
         end
         default: cls.node_bad = 1'b1;
      endcase
   end

endmodule

/* sv/ebsc_walk.sv */
// ----------------------------------------------------------------------------
// ebsc_walk
// Walks the event and its sub-blocks one word per step, keeps the per-event
// tallies and forms the summary on the last word of the event.
// ----------------------------------------------------------------------------
module ebsc_walk
   import ebsc_pkg::*;
#(
   parameter int ERROR_COUNT_MAX = 255
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WORD_W-1:0] word,
   output logic              finish,
   output summary_type       summary
);

   localparam int ERR_W = $clog2(ERROR_COUNT_MAX + 1);
   localparam logic [ERR_W-1:0] ERR_MAX = ERR_W'(ERROR_COUNT_MAX);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  len_ff, len_in, len_upd;
   logic [NHP_W-1:0]  nhp_ff, nhp_in, nhp_upd;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              cap_ff, cap_in, cap_upd;
   logic [CNT_W-1:0]  main_ff [3];
   logic [CNT_W-1:0]  main_in [3];
   logic [CNT_W-1:0]  main_upd [3];
   logic [CNT_W-1:0]  ctr_ff [8];
   logic [CNT_W-1:0]  ctr_in [8];
   logic [CNT_W-1:0]  ctr_upd [8];
   logic [CNT_W-1:0]  trk_ff [12];
   logic [CNT_W-1:0]  trk_in [12];
   logic [CNT_W-1:0]  trk_upd [12];
   logic [ERR_W-1:0]  type_err_ff, type_err_in, type_err_upd;
   logic [ERR_W-1:0]  node_err_ff, node_err_in, node_err_upd;
   logic              hdr_bad_ff, hdr_bad_in, hdr_bad_upd;
   logic              sbad_ff, sbad_in, sbad_upd;
   logic [WORD_W-1:0] gen_ff [8];
   logic [WORD_W-1:0] gen_in [8];
   logic [WORD_W-1:0] gen_upd [8];

   class_type         cls;
   logic              do_class;
   logic [2:0]        gen_idx;
   logic              single;
   logic [ERR_W+7:0]  type_err_ext;
   logic [ERR_W+7:0]  node_err_ext;

   ebsc_classify u_classify (
      .id  (word),
      .cls (cls)
   );

   assign gen_idx = 3'(off_ff - OFF_GEN_LO);

   always_comb begin
      pos_in       = pos_ff;
      off_in       = off_ff;
      len_upd      = len_ff;
      nhp_upd      = nhp_ff;
      cap_upd      = cap_ff;
      type_err_upd = type_err_ff;
      node_err_upd = node_err_ff;
      hdr_bad_upd  = hdr_bad_ff;
      sbad_upd     = sbad_ff;
      main_upd     = main_ff;
      ctr_upd      = ctr_ff;
      trk_upd      = trk_ff;
      gen_upd      = gen_ff;
      finish       = 1'b0;
      do_class     = 1'b0;

      priority if (pos_ff == '0) begin
         len_upd = POS_W'(word);
         off_in  = '0;
         pos_in  = POS_W'(1);
      end else if (pos_ff == POS_W'(1)) begin
         if ((word & ID_UPPER_MASK) == '0) begin
            len_upd = len_ff | {word[5:0] & ID_EXT_MASK[5:0], 16'h0000};
         end else begin
            hdr_bad_upd = 1'b1;
         end
         if (len_upd <= POS_W'(1)) finish = 1'b1;
         else pos_in = POS_W'(2);
      end else begin
         do_class = (off_ff == OFF_ID);
         if (do_class) begin
            if (cls.btype_bad && type_err_ff < ERR_MAX) type_err_upd = type_err_ff + 1'b1;
            if (cls.node_bad && node_err_ff < ERR_MAX) node_err_upd = node_err_ff + 1'b1;
            for (int i = 0; i < 3; i++)
               if (cls.main_hit[i] && main_ff[i] != CNT_SAT) main_upd[i] = main_ff[i] + 1'b1;
            for (int i = 0; i < 8; i++)
               if (cls.counter_hit[i] && ctr_ff[i] != CNT_SAT) ctr_upd[i] = ctr_ff[i] + 1'b1;
            for (int i = 0; i < 12; i++)
               if (cls.tracker_hit[i] && trk_ff[i] != CNT_SAT) trk_upd[i] = trk_ff[i] + 1'b1;
            if (cls.main_hit[0] && main_ff[0] == '0) cap_upd = 1'b1;
         end else if (cap_ff && off_ff >= OFF_GEN_LO && off_ff <= OFF_GEN_HI) begin
            gen_upd[gen_idx] = word;
         end

         if (NHP_W'(pos_ff) == nhp_ff) begin
            if (word == '0) sbad_upd = 1'b1;
            if (pos_ff == len_ff) sbad_upd = 1'b1;
            nhp_upd = nhp_ff + NHP_W'(word) + NHP_W'(1);
            off_in  = OFF_ID;
            cap_upd = 1'b0;
         end else begin
            off_in = (off_ff < OFF_MAX) ? off_ff + 1'b1 : OFF_MAX;
         end

         if (pos_ff >= len_ff) finish = 1'b1;
         else pos_in = pos_ff + 1'b1;
      end
   end

   always_comb begin
      single       = (main_upd[0] == CNT_SAT - 1'b1);
      type_err_ext = {8'h00, type_err_upd};
      node_err_ext = {8'h00, node_err_upd};
      summary = '0;
      summary.header_id_bad    = hdr_bad_upd;
      summary.structure_bad    = sbad_upd || (nhp_upd != NHP_W'(len_upd) + NHP_W'(1));
      summary.type_error_count = type_err_ext[OUT_ERR_W-1:0];
      summary.node_error_count = node_err_ext[OUT_ERR_W-1:0];
      for (int i = 0; i < 3; i++)  summary.main_single_mask[i] = (main_upd[i] == 2'd1);
      for (int i = 0; i < 8; i++)  summary.counter_single_mask[i] = (ctr_upd[i] == 2'd1);
      for (int i = 0; i < 12; i++) summary.tracker_single_mask[i] = (trk_upd[i] == 2'd1);
      if (single) begin
         summary.run_id      = {gen_upd[0], gen_upd[1]};
         summary.run_mode    = gen_upd[2];
         summary.run_tag     = gen_upd[3];
         summary.evt_serial  = {gen_upd[4], gen_upd[5]};
         summary.evt_seconds = {gen_upd[6], gen_upd[7]};
      end
   end

   always_comb begin
      len_in      = len_upd;
      nhp_in      = nhp_upd;
      cap_in      = cap_upd;
      type_err_in = type_err_upd;
      node_err_in = node_err_upd;
      hdr_bad_in  = hdr_bad_upd;
      sbad_in     = sbad_upd;
      main_in     = main_upd;
      ctr_in      = ctr_upd;
      trk_in      = trk_upd;
      gen_in      = gen_upd;
      if (finish) begin
         len_in      = '0;
         nhp_in      = FIRST_HEADER_POS;
         cap_in      = 1'b0;
         type_err_in = '0;
         node_err_in = '0;
         hdr_bad_in  = 1'b0;
         sbad_in     = 1'b0;
         for (int i = 0; i < 3; i++)  main_in[i] = '0;
         for (int i = 0; i < 8; i++)  ctr_in[i] = '0;
         for (int i = 0; i < 12; i++) trk_in[i] = '0;
         for (int i = 0; i < 8; i++)  gen_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         nhp_ff      <= FIRST_HEADER_POS;
         off_ff      <= '0;
         cap_ff      <= 1'b0;
         type_err_ff <= '0;
         node_err_ff <= '0;
         hdr_bad_ff  <= 1'b0;
         sbad_ff     <= 1'b0;
         for (int i = 0; i < 3; i++)  main_ff[i] <= '0;
         for (int i = 0; i < 8; i++)  ctr_ff[i] <= '0;
         for (int i = 0; i < 12; i++) trk_ff[i] <= '0;
         for (int i = 0; i < 8; i++)  gen_ff[i] <= '0;
      end else if (step) begin
         pos_ff      <= finish ? '0 : pos_in;
         len_ff      <= len_in;
         nhp_ff      <= nhp_in;
         off_ff      <= finish ? '0 : off_in;
         cap_ff      <= cap_in;
         type_err_ff <= type_err_in;
         node_err_ff <= node_err_in;
         hdr_bad_ff  <= hdr_bad_in;
         sbad_ff     <= sbad_in;
         main_ff     <= main_in;
         ctr_ff      <= ctr_in;
         trk_ff      <= trk_in;
         gen_ff      <= gen_in;
      end
   end

endmodule

/* sv/event_block_structure_checker_core.sv */
// ----------------------------------------------------------------------------
// event_block_structure_checker_core
// Checks the structure of a stream of event blocks and reports one summary
// beat per event.
//
//   Channel   Dir   Beat
//   req       in    one 16-bit stream word
//   rsp       out   one event summary, on the event's last word
//
// One word per cycle is taken in steady state. A word is walked in the cycle
// it sits in the input register, and an event's summary is loaded into the
// result register at the end of that cycle, so it is offered from the result
// register once the event's last word has been walked. A stalled summary
// holds the walk, and an empty input register still takes one more word.
// Reset clears all per-event state.
// ----------------------------------------------------------------------------
module event_block_structure_checker_core
   import ebsc_pkg::*;
#(
   parameter int ERROR_COUNT_MAX = 255
)(
   input  logic       clock,
   input  logic       reset,
   ebsc_req_if.sink   req,
   ebsc_rsp_if.source rsp
);

   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   summary_type       summary_ff;
   summary_type       summary;
   logic              advance;
   logic              finish;
   logic              req_take;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign req_take    = req.valid && req.ready;

   ebsc_walk #(
      .ERROR_COUNT_MAX (ERROR_COUNT_MAX)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .word    (in_word_ff),
      .finish  (finish),
      .summary (summary)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance && finish) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_word_ff <= req.word;
      if (advance && finish) summary_ff <= summary;
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.header_id_bad       = summary_ff.header_id_bad;
   assign rsp.structure_bad       = summary_ff.structure_bad;
   assign rsp.type_error_count    = summary_ff.type_error_count;
   assign rsp.node_error_count    = summary_ff.node_error_count;
   assign rsp.main_single_mask    = summary_ff.main_single_mask;
   assign rsp.counter_single_mask = summary_ff.counter_single_mask;
   assign rsp.tracker_single_mask = summary_ff.tracker_single_mask;
   assign rsp.run_id              = summary_ff.run_id;
   assign rsp.run_mode            = summary_ff.run_mode;
   assign rsp.run_tag             = summary_ff.run_tag;
   assign rsp.evt_serial          = summary_ff.evt_serial;
   assign rsp.evt_seconds         = summary_ff.evt_seconds;

   a_generic_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !summary_ff.main_single_mask[0] |->
         summary_ff.run_id == '0 && summary_ff.run_mode == '0 &&
         summary_ff.run_tag == '0 && summary_ff.evt_serial == '0 &&
         summary_ff.evt_seconds == '0)
      else $error("generic fields set without a single generic block");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && finish))
      else $error("summary beat raised without a finished event");

   a_take_frees: assert property (@(posedge clock) disable iff (reset)
      req_take && in_valid_ff |-> advance)
      else $error("word taken while the input register is held");

endmodule
